// ----- rtl/assert_macros.svh -----
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion checked on the rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold on a rising clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/bba_pkg.sv -----
// shared types and constants of the buddy block allocator
package bba_pkg;

  localparam int unsigned Leaves = 16;
  localparam int unsigned MaxOrder = 4;
  localparam int unsigned LeafW = $clog2(Leaves);
  localparam int unsigned OrdW = 4;
  localparam int unsigned OwnW = 8;
  localparam int unsigned UnitW = 13;
  localparam int unsigned SizeW = 20;
  localparam int unsigned KbW = SizeW;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdRelease = 1'b1;

  localparam logic [2:0] RegUnitSizeAddr = 3'd0;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_next;
    logic split_step;
    logic take_alloc;
    logic take_release;
    logic merge_step;
    logic fail;
  } ctrl_t;

  typedef struct packed {
    logic is_release;
    logic scan_done;
    logic hit;
    logic can_split;
    logic can_merge;
  } stat_t;

endpackage

// ----- rtl/bba_datapath.sv -----
// block table, scan pointer and split/merge datapath
module bba_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bba_pkg::ctrl_t             ctrl_i,
  output bba_pkg::stat_t             stat_o,
  input  logic                       cmd_i,
  input  logic [bba_pkg::OwnW-1:0]   owner_i,
  input  logic [bba_pkg::SizeW-1:0]  size_i,
  input  logic [bba_pkg::UnitW-1:0]  unit_i,
  output logic                       res_ok_o,
  output logic [bba_pkg::SizeW-1:0]  res_addr_o,
  output logic [2:0]                 res_ord_o
);

  logic [bba_pkg::Leaves-1:0]                   free_q;
  logic [bba_pkg::Leaves-1:0][bba_pkg::OrdW-1:0] ord_q;
  logic [bba_pkg::Leaves-1:0][bba_pkg::OwnW-1:0] own_q;

  logic                      cmd_q;
  logic [bba_pkg::OwnW-1:0]  owner_q;
  logic [bba_pkg::SizeW-1:0] size_q;
  logic [bba_pkg::LeafW:0]   idx_q;
  logic [bba_pkg::OrdW-1:0]  n_q;
  logic [bba_pkg::LeafW-1:0] a_q;

  logic [bba_pkg::LeafW-1:0] idx;
  logic [bba_pkg::OrdW-1:0]  cur_ord;
  logic [bba_pkg::KbW-1:0]   kb_cur, kb_half;
  logic [bba_pkg::LeafW:0]   step;
  logic [bba_pkg::LeafW:0]   buddy;
  logic [bba_pkg::LeafW-1:0] bud;
  logic [bba_pkg::LeafW-1:0] half_ix;
  logic [bba_pkg::OrdW-1:0]  n_m1;

  assign idx     = idx_q[bba_pkg::LeafW-1:0];
  assign cur_ord = ord_q[idx];
  assign kb_cur  = bba_pkg::KbW'(unit_i) << cur_ord;
  assign n_m1    = n_q - 1'b1;
  assign kb_half = bba_pkg::KbW'(unit_i) << n_m1;
  assign step    = (bba_pkg::LeafW+1)'(1) << cur_ord;
  assign half_ix = a_q + bba_pkg::LeafW'((bba_pkg::LeafW+1)'(1) << n_m1);
  assign buddy   = {1'b0, a_q} ^ ((bba_pkg::LeafW+1)'(1) << n_q);
  assign bud     = buddy[bba_pkg::LeafW-1:0];

  assign stat_o.is_release = cmd_q;
  assign stat_o.scan_done  = idx_q[bba_pkg::LeafW];
  assign stat_o.hit = !idx_q[bba_pkg::LeafW] &&
                      (cmd_q ? (!free_q[idx] && own_q[idx] == owner_q)
                             : (free_q[idx] && kb_cur >= bba_pkg::KbW'(size_q)));
  assign stat_o.can_split = n_q != '0 && kb_half >= bba_pkg::KbW'(size_q);
  assign stat_o.can_merge = n_q < bba_pkg::OrdW'(bba_pkg::MaxOrder) &&
                            !buddy[bba_pkg::LeafW] && free_q[bud] && ord_q[bud] == n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= bba_pkg::Leaves'(1);
      ord_q  <= (bba_pkg::Leaves*bba_pkg::OrdW)'(bba_pkg::MaxOrder);
      own_q  <= '0;
      idx_q  <= '0;
      n_q    <= '0;
      a_q    <= '0;
    end else begin
      if (ctrl_i.scan_start) idx_q <= '0;
      if (ctrl_i.scan_next) idx_q <= idx_q + step;
      if (ctrl_i.take_alloc) begin
        a_q <= idx;
        n_q <= cur_ord;
        free_q[idx] <= 1'b0;
        own_q[idx] <= owner_q;
      end
      if (ctrl_i.split_step) begin
        n_q <= n_m1;
        free_q[half_ix] <= 1'b1;
        ord_q[half_ix] <= n_m1;
        own_q[half_ix] <= '0;
        ord_q[a_q] <= n_m1;
      end
      if (ctrl_i.take_release) begin
        a_q <= idx;
        n_q <= cur_ord;
        free_q[idx] <= 1'b1;
        own_q[idx] <= '0;
      end
      if (ctrl_i.merge_step) begin
        if (bud < a_q) a_q <= bud;
        n_q <= n_q + 1'b1;
        ord_q[(bud < a_q) ? bud : a_q] <= n_q + 1'b1;
        free_q[(bud < a_q) ? bud : a_q] <= 1'b1;
        own_q[(bud < a_q) ? bud : a_q] <= '0;
      end
    end
  end

  logic [bba_pkg::LeafW+bba_pkg::UnitW-1:0] prod;
  assign prod = (bba_pkg::LeafW+bba_pkg::UnitW)'(idx) *
                (bba_pkg::LeafW+bba_pkg::UnitW)'(unit_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= cmd_i;
      owner_q <= owner_i;
      size_q  <= size_i;
    end
    if (ctrl_i.take_alloc || ctrl_i.take_release) begin
      res_ok_o   <= 1'b1;
      res_addr_o <= bba_pkg::SizeW'(prod);
    end
    if (ctrl_i.take_release) res_ord_o <= cur_ord[2:0];
    if (ctrl_i.take_alloc) res_ord_o <= cur_ord[2:0];
    if (ctrl_i.split_step) res_ord_o <= n_m1[2:0];
    if (ctrl_i.fail) begin
      res_ok_o   <= 1'b0;
      res_addr_o <= '0;
      res_ord_o  <= '0;
    end
  end

endmodule

// ----- rtl/bba_ctrl.sv -----
// request sequencer and output register control
`include "assert_macros.svh"
module bba_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bba_pkg::ctrl_t ctrl_o,
  input  bba_pkg::stat_t stat_i
);

  typedef enum logic [2:0] {
    StIdle, StScan, StSplit, StMerge, StDone
  } state_e;

  state_e state_q;

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = state_q == StDone;

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      StIdle: begin
        ctrl_o.load = in_valid_i;
        ctrl_o.scan_start = in_valid_i;
      end
      StScan: begin
        if (stat_i.scan_done) ctrl_o.fail = 1'b1;
        else if (stat_i.hit) begin
          ctrl_o.take_alloc = !stat_i.is_release;
          ctrl_o.take_release = stat_i.is_release;
        end else ctrl_o.scan_next = 1'b1;
      end
      StSplit: ctrl_o.split_step = stat_i.can_split;
      StMerge: ctrl_o.merge_step = stat_i.can_merge;
      default: ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: if (in_valid_i) state_q <= StScan;
        StScan: begin
          if (stat_i.scan_done) state_q <= StDone;
          else if (stat_i.hit) state_q <= stat_i.is_release ? StMerge : StSplit;
        end
        StSplit: if (!stat_i.can_split) state_q <= StDone;
        StMerge: if (!stat_i.can_merge) state_q <= StDone;
        StDone: if (out_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  `ASSERT_NEVER(a_one_take, clk_i, rst_ni, ctrl_o.take_alloc && ctrl_o.take_release, "both takes")
  `ASSERT_CLK(a_load_idle, clk_i, rst_ni, ctrl_o.load |-> state_q == StIdle, "load not idle")
  `ASSERT_CLK(a_done_follows, clk_i, rst_ni, ctrl_o.fail |=> out_valid_o, "fail without result")

endmodule

// ----- rtl/buddy_block_allocator.sv -----
// Buddy allocator over 16 leaf units of unit_size KB. One request at a time: the
// sequencer walks the block table one block per cycle, then splits one level per
// cycle on allocate or merges one level per cycle on release (up to 4 levels), and
// holds the result until the output transfer completes.
module buddy_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // command, owner_id, request_size, zero pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // success, block_address, block_order
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [bba_pkg::UnitW-1:0] unit_q;
  bba_pkg::ctrl_t ctrl;
  bba_pkg::stat_t stat;
  logic ok;
  logic [bba_pkg::SizeW-1:0] addr;
  logic [2:0] ord;

  assign pready = 1'b1;
  assign prdata = (paddr == bba_pkg::RegUnitSizeAddr) ? {19'd0, unit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= bba_pkg::UnitW'(4);
    end else if (psel && penable && pwrite && paddr == bba_pkg::RegUnitSizeAddr) begin
      unit_q <= pwdata[bba_pkg::UnitW-1:0];
    end
  end

  bba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .ctrl_o(ctrl), .stat_i(stat)
  );

  bba_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cmd_i(s_axis_tdata_i[0]), .owner_i(s_axis_tdata_i[8:1]),
    .size_i(s_axis_tdata_i[28:9]), .unit_i(unit_q),
    .res_ok_o(ok), .res_addr_o(addr), .res_ord_o(ord)
  );

  assign m_axis_tdata_o = {ord, addr, ok};

endmodule

// ----- bench/bba_checker.sv -----
// checker for the buddy block allocator: tracks the block table and compares results
`timescale 1ns / 100ps

module bba_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          granted_o
);

  // packed from the lowest bit up: success, address, order
  typedef struct packed {
    logic [2:0]  order;
    logic [19:0] address;
    logic        success;
  } grant_t;

  logic [bba_pkg::UnitW-1:0] unit_kb;
  logic                      leaf_free  [bba_pkg::Leaves];
  logic [bba_pkg::OrdW-1:0]  leaf_order [bba_pkg::Leaves];
  logic [bba_pkg::OwnW-1:0]  leaf_owner [bba_pkg::Leaves];
  grant_t                    grant_q[$];

  function automatic longint unsigned block_kb(int unsigned ord);
    return (longint'(1) << ord) * longint'(unit_kb);
  endfunction

  function automatic grant_t make_grant(int unsigned leaf, int unsigned ord);
    grant_t g;
    longint unsigned addr;
    addr = longint'(leaf) * longint'(unit_kb);
    g.success = 1'b1;
    g.address = addr[19:0];
    g.order = ord[2:0];
    return g;
  endfunction

  function automatic grant_t allocate_block(logic [bba_pkg::OwnW-1:0] who,
                                            logic [bba_pkg::SizeW-1:0] kb);
    int unsigned i, n, bud;
    i = 0;
    while (i < bba_pkg::Leaves) begin
      n = leaf_order[i];
      if (leaf_free[i] && block_kb(n) >= kb) begin
        while (n > 0 && block_kb(n - 1) >= kb) begin
          n--;
          bud = i + (1 << n);
          if (bud < bba_pkg::Leaves) begin
            leaf_free[bud] = 1'b1;
            leaf_order[bud] = n[bba_pkg::OrdW-1:0];
            leaf_owner[bud] = '0;
          end
        end
        leaf_order[i] = n[bba_pkg::OrdW-1:0];
        leaf_free[i] = 1'b0;
        leaf_owner[i] = who;
        return make_grant(i, n);
      end
      i += 1 << n;
    end
    return '0;
  endfunction

  function automatic grant_t release_block(logic [bba_pkg::OwnW-1:0] who);
    int unsigned i, n, a, o, b;
    grant_t g;
    i = 0;
    while (i < bba_pkg::Leaves) begin
      n = leaf_order[i];
      if (!leaf_free[i] && leaf_owner[i] == who) begin
        g = make_grant(i, n);
        a = i;
        o = n;
        leaf_free[i] = 1'b1;
        leaf_owner[i] = '0;
        while (o < bba_pkg::MaxOrder) begin
          b = a ^ (1 << o);
          if (b >= bba_pkg::Leaves || !leaf_free[b] || leaf_order[b] != o) break;
          if (b < a) a = b;
          o++;
          leaf_order[a] = o[bba_pkg::OrdW-1:0];
          leaf_free[a] = 1'b1;
          leaf_owner[a] = '0;
        end
        return g;
      end
      i += 1 << n;
    end
    return '0;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t got, want;
    if (!rst_ni) begin
      unit_kb = 13'd4;
      for (int k = 0; k < bba_pkg::Leaves; k++) begin
        leaf_free[k] = 1'b0;
        leaf_order[k] = '0;
        leaf_owner[k] = '0;
      end
      leaf_free[0] = 1'b1;
      leaf_order[0] = bba_pkg::OrdW'(bba_pkg::MaxOrder);
      grant_q.delete();
      fail_count_o = 0;
      granted_o = 0;
      pending_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i == bba_pkg::RegUnitSizeAddr)
        unit_kb = pwdata_i[bba_pkg::UnitW-1:0];
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        if (grant_q.size() == 0) begin
          report("unexpected transfer", m_tdata_i, '0);
        end else begin
          want = grant_q.pop_front();
          if (got.success != want.success) report("success", got.success, want.success);
          if (got.address != want.address) report("block_address", got.address, want.address);
          if (got.order != want.order) report("block_order", got.order, want.order);
          if (want.success) granted_o++;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tdata_i[0] == bba_pkg::CmdAlloc)
          grant_q.insert(grant_q.size(), allocate_block(s_tdata_i[8:1], s_tdata_i[28:9]));
        else
          grant_q.insert(grant_q.size(), release_block(s_tdata_i[8:1]));
      end
      pending_o = grant_q.size();
    end
  end

endmodule

// ----- bench/tb_buddy_block_allocator.sv -----
// testbench top for the buddy block allocator: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_buddy_block_allocator;

  logic        clk;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending, granted;
  int          hold_cycles;
  int          stall_pct;
  int          requests_sent;
  int          unit_cur;
  int          phases_run;

  buddy_block_allocator DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bba_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending), .granted_o(granted)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  // receiver stall pattern, with an optional long hold-off
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic reg_write(logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= bba_pkg::RegUnitSizeAddr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    unit_cur = value[bba_pkg::UnitW-1:0];
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_request(logic cmd, logic [7:0] who, logic [19:0] kb, int gap);
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, kb, who, cmd};
    do @(posedge clk); while (!s_tready);
    requests_sent++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [19:0] pick_size();
    int r;
    longint unsigned base;
    r = $urandom_range(0, 99);
    base = longint'(unit_cur) << $urandom_range(0, 5);
    if (r < 8) return 20'd0;
    if (r < 18) return 20'($urandom_range(0, 20'hFFFFF));
    if (r < 60) return base[19:0];
    if (r < 80) return base[19:0] + 20'd1;
    return base[19:0] - 20'($urandom_range(0, 3));
  endfunction

  task automatic random_phase(int count);
    int burst, gap;
    logic [7:0] who;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      who = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap = $urandom_range(1, 8);
      end else begin
        gap = 0;
      end
      burst--;
      if (burst != 0) gap = 0;
      if ($urandom_range(0, 99) < 55)
        send_request(bba_pkg::CmdAlloc, who, pick_size(), gap);
      else
        send_request(bba_pkg::CmdRelease, who, 20'($urandom), gap);
    end
  endtask

  initial begin
    int units[7];
    units = '{4, 1, 4096, 0, 8191, 13, 64};
    rst_n = 1'b0;
    s_tvalid = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_cycles = 0; stall_pct = 30; requests_sent = 0; unit_cur = 4; phases_run = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero size, misses, full split and full merge
    send_request(bba_pkg::CmdAlloc, 8'd0, 20'd0, 0);
    send_request(bba_pkg::CmdAlloc, 8'd255, 20'hFFFFF, 0);
    send_request(bba_pkg::CmdRelease, 8'd77, 20'hFFFFF, 0);
    send_request(bba_pkg::CmdAlloc, 8'd255, 20'd64, 2);
    send_request(bba_pkg::CmdAlloc, 8'd1, 20'd5, 0);
    send_request(bba_pkg::CmdAlloc, 8'd2, 20'd16, 0);
    send_request(bba_pkg::CmdRelease, 8'd0, 20'd0, 0);
    send_request(bba_pkg::CmdRelease, 8'd1, 20'd0, 1);
    send_request(bba_pkg::CmdRelease, 8'd2, 20'd0, 0);
    send_request(bba_pkg::CmdRelease, 8'd255, 20'd0, 0);
    send_request(bba_pkg::CmdAlloc, 8'hAA, 20'h55555, 0);
    send_request(bba_pkg::CmdAlloc, 8'h55, 20'hAAAAA, 0);
    send_request(bba_pkg::CmdAlloc, 8'd3, 20'd4, 0);
    send_request(bba_pkg::CmdRelease, 8'd3, 20'd0, 0);
    drain();

    foreach (units[p]) begin
      reg_write(units[p]);
      stall_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 70);
      if (p == 1) hold_cycles <= 300;
      send_request(bba_pkg::CmdAlloc, 8'd9, 20'd0, 0);
      send_request(bba_pkg::CmdAlloc, 8'd200, 20'(unit_cur * 16), 0);
      random_phase(110);
      // release one block of each owner 0 to 7 before moving to the next unit size
      for (int w = 0; w < 8; w++) send_request(bba_pkg::CmdRelease, w[7:0], 20'd0, 0);
      drain();
      phases_run++;
    end
    reg_write($urandom_range(1, 4096));
    stall_pct = 20;
    random_phase(40);
    drain();
    phases_run++;

    $display("ran %0d requests over %0d unit-size settings, %0d granted",
             requests_sent, phases_run, granted);
    $display("covered long output stalls, bursts with gaps and zero and full-range sizes");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
